FILE: hdl/arpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the audio record/playback controller.
// No dependencies; imported by arpc_ctrl and the top level.
package arpc_pkg;

	localparam int DEF_STORE_DEPTH = 16384;
	localparam int DEF_SAMPLE_BITS = 12;

	localparam int OP_BITS    = 3;
	localparam int MODE_BITS  = 2;
	localparam int LIMIT_BITS = 15;
	localparam int INDEX_BITS = 14;
	localparam int DAC_BITS   = 10;
	localparam int LAMP_BITS  = 3;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16000);

	// event codes
	localparam logic [OP_BITS-1:0] OP_REC_BTN  = 3'd0;
	localparam logic [OP_BITS-1:0] OP_PLAY_BTN = 3'd1;
	localparam logic [OP_BITS-1:0] OP_SEND_BTN = 3'd2;
	localparam logic [OP_BITS-1:0] OP_DUR_END  = 3'd3;
	localparam logic [OP_BITS-1:0] OP_TICK     = 3'd4;
	localparam logic [OP_BITS-1:0] OP_ADC      = 3'd5;
	localparam logic [OP_BITS-1:0] OP_SEND_END = 3'd6;
	localparam logic [OP_BITS-1:0] OP_READ     = 3'd7;

	// operating modes
	localparam logic [MODE_BITS-1:0] MODE_IDLE = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_REC  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_PLAY = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_SEND = 2'd3;

	// lamp bit positions
	localparam int LAMP_REC  = 0;
	localparam int LAMP_PLAY = 1;
	localparam int LAMP_SEND = 2;

	// per-transaction status handed from the control unit to the output stages
	typedef struct packed {
		logic                 dac_write;
		logic                 dac_live;   // store entry was written, else reads zero
		logic                 read_live;  // read of a written entry
		logic [LAMP_BITS-1:0] lamps;
		logic [MODE_BITS-1:0] mode;
		logic                 ready;
		logic                 overrun;
		logic                 timeout;
	} arpc_status_t;

endpackage

FILE: hdl/audio_record_playback_controller_core.sv
`timescale 1ns / 1ps
// Top level of the voice recorder mode controller: control unit, sample store
// and output pipeline. Depends on arpc_pkg, arpc_ctrl and arpc_ram.

// One event is accepted per clock while in_stall is low, a sustained rate of one
// event per cycle while out_stall is low, and yields exactly one result, held in
// stage 1 beside the registered store read and then in the output register. The
// mode, position, flags and lamps are updated, and the store written or read, in
// the accept cycle, so back-to-back events see each other's writes with no
// forwarding. The store needs no clearing pass after reset: because samples are
// always written from position zero upward, a fill mark records how far the
// store has ever been written, and any read at or beyond it returns zero. The
// sample_limit register (reset 16000) may be written over its valid/ready port
// while the block is idle; cfg_ready is always high. in_stall rises only when
// a result is held in the output register under out_stall and the next result
// is already waiting on the store read.
module audio_record_playback_controller_core #(
	parameter int STORE_DEPTH = arpc_pkg::DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS = arpc_pkg::DEF_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// event channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [arpc_pkg::OP_BITS-1:0]      opcode,
	input  logic [SAMPLE_BITS-1:0]            adc_sample,
	input  logic                              adc_overrun,
	input  logic                              send_failed,
	input  logic [arpc_pkg::INDEX_BITS-1:0]   read_index,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              dac_write,
	output logic [arpc_pkg::DAC_BITS-1:0]     dac_value,
	output logic [SAMPLE_BITS-1:0]            read_data,
	output logic                              led_record,
	output logic                              led_play,
	output logic                              led_send,
	output logic [arpc_pkg::MODE_BITS-1:0]    mode,
	output logic                              recording_ready,
	output logic                              overrun_error,
	output logic                              timeout_error,
	// sample_limit register write
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [arpc_pkg::LIMIT_BITS-1:0]   sample_limit
);
	import arpc_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);

	logic                   accept, adv;
	arpc_status_t           status_c, status_s1, status_q;
	logic                   valid_s1, out_valid_q;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;
	logic [SAMPLE_BITS+DAC_BITS-1:0] dac_ext;
	logic [DAC_BITS-1:0]    dac_value_q;
	logic [SAMPLE_BITS-1:0] read_data_q;

	// handshakes
	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;

	arpc_ctrl #(
		.STORE_DEPTH(STORE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.adc_sample (adc_sample),
		.adc_overrun(adc_overrun),
		.send_failed(send_failed),
		.read_index (read_index),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (sample_limit),
		.status     (status_c),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr)
	);

	arpc_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// top ten bits of the sample, zero-padded below when samples are narrower
	assign dac_ext = {mem_rdata, DAC_BITS'(0)};

	// stage 1: status waits here while the store read completes.
	// The store read register only reloads on accept, so it holds while s1 stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q    <= status_s1;
			dac_value_q <= status_s1.dac_live ?
				dac_ext[SAMPLE_BITS+DAC_BITS-1 -: DAC_BITS] : '0;
			read_data_q <= status_s1.read_live ? mem_rdata : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign dac_write       = status_q.dac_write;
	assign dac_value       = dac_value_q;
	assign read_data       = read_data_q;
	assign led_record      = status_q.lamps[LAMP_REC];
	assign led_play        = status_q.lamps[LAMP_PLAY];
	assign led_send        = status_q.lamps[LAMP_SEND];
	assign mode            = status_q.mode;
	assign recording_ready = status_q.ready;
	assign overrun_error   = status_q.overrun;
	assign timeout_error   = status_q.timeout;

	// a playback value is only ever presented while playing, never with read data
	a_dac_in_play: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dac_write |-> mode == MODE_PLAY && read_data == '0)
		else $error("dac value presented outside playback");

	// an overrun leaves the block idle with every lamp lit until cleared
	a_overrun_lamps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun_error |-> mode == MODE_IDLE && led_record && led_play && led_send)
		else $error("overrun state inconsistent");

	// the input side only backs up behind a held output transaction
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && valid_s1)
		else $error("input stalled without a held result");

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status_q) && $stable(read_data_q))
		else $error("stalled result changed");

endmodule

FILE: hdl/arpc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module arpc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16384,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/arpc_ctrl.sv
`timescale 1ns / 1ps
// Mode/flag/lamp state, sample position, fill mark and store access decode.
// Depends on arpc_pkg.
module arpc_ctrl #(
	parameter int STORE_DEPTH = arpc_pkg::DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS = arpc_pkg::DEF_SAMPLE_BITS,
	localparam int AW = $clog2(STORE_DEPTH),
	localparam int PW = $clog2(STORE_DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [arpc_pkg::OP_BITS-1:0]      opcode,
	input  logic [SAMPLE_BITS-1:0]            adc_sample,
	input  logic                              adc_overrun,
	input  logic                              send_failed,
	input  logic [arpc_pkg::INDEX_BITS-1:0]   read_index,
	input  logic                              cfg_we,
	input  logic [arpc_pkg::LIMIT_BITS-1:0]   cfg_data,
	output arpc_pkg::arpc_status_t            status,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_waddr,
	output logic [SAMPLE_BITS-1:0]            mem_wdata,
	output logic                              mem_re,
	output logic [AW-1:0]                     mem_raddr
);
	import arpc_pkg::*;

	localparam int CW0 = (PW > LIMIT_BITS) ? PW : LIMIT_BITS;
	localparam int CW  = (CW0 > INDEX_BITS) ? CW0 : INDEX_BITS;

	logic [MODE_BITS-1:0]  mode_q, mode_d;
	logic [PW-1:0]         pos_q, pos_d, hwm_q, hwm_d, lim_eff, pos_inc;
	logic [LIMIT_BITS-1:0] limit_q;
	logic                  ready_q, ready_d, ovr_q, ovr_d, tmo_q, tmo_d;
	logic [LAMP_BITS-1:0]  lamp_q, lamp_d;
	logic [CW-1:0]         lim_x, depth_x, ridx_x;
	logic                  may_start, pos_ok, ridx_ok;
	logic                  we_c, re_c, dac_write_c, read_live_c;

	assign lim_x     = CW'(limit_q);
	assign depth_x   = CW'(STORE_DEPTH);
	assign ridx_x    = CW'(read_index);
	assign lim_eff   = (lim_x < depth_x) ? lim_x[PW-1:0] : PW'(STORE_DEPTH);
	assign pos_ok    = pos_q < lim_eff;
	assign ridx_ok   = ridx_x < CW'(hwm_q);
	assign pos_inc   = pos_q + PW'(1);
	assign may_start = (mode_q == MODE_IDLE) && !ovr_q && !tmo_q && ready_q;

	always_comb begin
		mode_d      = mode_q;
		pos_d       = pos_q;
		hwm_d       = hwm_q;
		ready_d     = ready_q;
		ovr_d       = ovr_q;
		tmo_d       = tmo_q;
		lamp_d      = lamp_q;
		we_c        = 1'b0;
		re_c        = 1'b0;
		dac_write_c = 1'b0;
		read_live_c = 1'b0;
		unique case (opcode)
			OP_REC_BTN: begin
				if (ovr_q || tmo_q) begin
					ovr_d  = 1'b0;
					tmo_d  = 1'b0;
					lamp_d = '0;
				end
				if (mode_q == MODE_IDLE) begin
					mode_d            = MODE_REC;
					lamp_d[LAMP_REC]  = 1'b1;
					pos_d             = '0;
				end
			end
			OP_PLAY_BTN: begin
				if (may_start) begin
					mode_d            = MODE_PLAY;
					lamp_d[LAMP_PLAY] = 1'b1;
					pos_d             = '0;
				end
			end
			OP_SEND_BTN: begin
				if (may_start) begin
					mode_d            = MODE_SEND;
					lamp_d[LAMP_SEND] = 1'b1;
				end
			end
			OP_DUR_END: begin
				if (mode_q == MODE_REC) begin
					mode_d           = MODE_IDLE;
					ready_d          = 1'b1;
					lamp_d[LAMP_REC] = 1'b0;
				end else if (mode_q == MODE_PLAY) begin
					mode_d            = MODE_IDLE;
					lamp_d[LAMP_PLAY] = 1'b0;
				end
			end
			OP_TICK: begin
				if (mode_q == MODE_PLAY && pos_ok) begin
					dac_write_c = 1'b1;
					re_c        = pos_q < hwm_q;
					pos_d       = pos_inc;
				end
			end
			OP_ADC: begin
				if (mode_q == MODE_REC) begin
					if (adc_overrun) begin
						ovr_d   = 1'b1;
						ready_d = 1'b0;
						mode_d  = MODE_IDLE;
						lamp_d  = '1;
					end else if (pos_ok) begin
						we_c  = 1'b1;
						pos_d = pos_inc;
						if (pos_inc > hwm_q) begin
							hwm_d = pos_inc;
						end
					end
				end
			end
			OP_SEND_END: begin
				if (mode_q == MODE_SEND) begin
					tmo_d = tmo_q | send_failed;
					if (tmo_d) begin
						lamp_d[LAMP_REC] = 1'b1;
					end else begin
						lamp_d[LAMP_SEND] = 1'b0;
					end
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				// read back; entries past the fill mark were never written and read zero
				re_c        = ridx_ok;
				read_live_c = ridx_ok;
			end
		endcase
	end

	assign mem_we    = accept && we_c;
	assign mem_waddr = pos_q[AW-1:0];
	assign mem_wdata = adc_sample;
	assign mem_re    = accept && re_c;
	assign mem_raddr = (opcode == OP_READ) ? ridx_x[AW-1:0] : pos_q[AW-1:0];

	always_comb begin
		status.dac_write = dac_write_c;
		status.dac_live  = dac_write_c && re_c;
		status.read_live = read_live_c;
		status.lamps     = lamp_d;
		status.mode      = mode_d;
		status.ready     = ready_d;
		status.overrun   = ovr_d;
		status.timeout   = tmo_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			hwm_q   <= '0;
			ready_q <= 1'b0;
			ovr_q   <= 1'b0;
			tmo_q   <= 1'b0;
			lamp_q  <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (accept) begin
				mode_q  <= mode_d;
				pos_q   <= pos_d;
				hwm_q   <= hwm_d;
				ready_q <= ready_d;
				ovr_q   <= ovr_d;
				tmo_q   <= tmo_d;
				lamp_q  <= lamp_d;
			end
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
		end
	end

endmodule
